FILE: rtl/bsta_pkg.sv
// shared types and codes for the byte stack typed access unit
`default_nettype none

package bsta_pkg;

  localparam int ADDR_W = 16;
  localparam int LANES  = 8;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_SET  = 3'd2;
  localparam logic [2:0] OP_GET  = 3'd3;
  localparam logic [2:0] OP_DROP = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  access_bytes;
    logic [11:0] byte_offset;
    logic [12:0] drop_count;
    logic [63:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  status;
    logic [12:0] depth;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic              read_en;
    logic              write_en;
    logic [3:0]        nbytes;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wdata;
    logic [1:0]        status;
    logic [12:0]       depth;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bsta_fifo.sv
// small register queue with occupancy count
`default_nettype none

module bsta_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [WIDTH-1:0]             wr_data,
  output logic                              full,
  input  wire logic                         rd_en,
  output logic [WIDTH-1:0]                  rd_data,
  output logic                              empty,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bsta_front.sv
// front end: bounds checks, status and top pointer tracking
`default_nettype none

module bsta_front #(
  parameter int DEPTH_BYTES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bsta_pkg::in_item_t in_item,
  input  wire logic              cmd_full,
  output logic                   cmd_wr,
  output bsta_pkg::cmd_t         cmd
);

  localparam int TW = $clog2(DEPTH_BYTES+1);
  localparam int CW = ((TW > 13) ? TW : 13) + 1;

  logic [TW-1:0] top_r, top_nxt;
  logic [CW-1:0] new_top;

  assign cmd_wr = push && !cmd_full;

  always_comb begin
    logic [3:0]    nsat;
    logic [CW-1:0] top_w, n_w, off_w, cnt_w, cap_w, addr_w;
    nsat   = (in_item.access_bytes > 4'd8) ? 4'd8 : in_item.access_bytes;
    top_w  = CW'(top_r);
    n_w    = CW'(nsat);
    off_w  = CW'(in_item.byte_offset);
    cnt_w  = CW'(in_item.drop_count);
    cap_w  = CW'(DEPTH_BYTES);
    addr_w = top_w;
    new_top = top_w;

    cmd          = '0;
    cmd.nbytes   = nsat;
    cmd.wdata    = in_item.write_value;
    cmd.status   = bsta_pkg::ST_OK;

    case (in_item.opcode)
      bsta_pkg::OP_PUSH: begin
        if (top_w + n_w > cap_w) begin
          cmd.status = bsta_pkg::ST_OVERFLOW;
        end else begin
          cmd.write_en = 1'b1;
          new_top      = top_w + n_w;
        end
      end
      bsta_pkg::OP_POP: begin
        if (n_w > top_w) begin
          cmd.status = bsta_pkg::ST_UNDERFLOW;
        end else begin
          cmd.read_en = 1'b1;
          new_top     = top_w - n_w;
          addr_w      = top_w - n_w;
        end
      end
      bsta_pkg::OP_SET, bsta_pkg::OP_GET: begin
        addr_w = off_w;
        if (off_w + n_w > top_w) begin
          cmd.status = bsta_pkg::ST_RANGE;
        end else if (in_item.opcode == bsta_pkg::OP_SET) begin
          cmd.write_en = 1'b1;
        end else begin
          cmd.read_en = 1'b1;
        end
      end
      bsta_pkg::OP_DROP: begin
        if (cnt_w > top_w) begin
          cmd.status = bsta_pkg::ST_UNDERFLOW;
        end else begin
          new_top = top_w - cnt_w;
        end
      end
      default: begin
        // unknown codes leave everything as is
      end
    endcase

    cmd.addr  = bsta_pkg::ADDR_W'(addr_w);
    cmd.depth = new_top[12:0];
    top_nxt   = cmd_wr ? TW'(new_top) : top_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bsta_back.sv
// back end: eight byte banks, access issue and read data assembly
`default_nettype none

module bsta_back #(
  parameter int DEPTH_BYTES = 4096,
  parameter int OUT_DEPTH   = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire bsta_pkg::cmd_t                cmd,
  output logic                               cmd_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                               res_wr,
  output bsta_pkg::out_item_t                res
);

  localparam int LANES = bsta_pkg::LANES;
  localparam int ROWS  = (DEPTH_BYTES + LANES - 1) / LANES;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH+1);
  localparam int HI_W  = bsta_pkg::ADDR_W - 3;

  logic             issue;
  logic [7:0][7:0]  bank_q;
  logic             s2_valid_r;
  logic [2:0]       s2_base_r;
  logic [3:0]       s2_n_r;
  logic             s2_read_r;
  logic [1:0]       s2_status_r;
  logic [12:0]      s2_depth_r;
  logic [63:0]      rd_value;

  // issue only when the result queue has room for this one and the one in flight
  assign issue   = cmd_valid &&
                   (({1'b0, out_count} + (CNT_W+1)'(s2_valid_r)) < (CNT_W+1)'(OUT_DEPTH));
  assign cmd_pop = issue;

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [2:0]      lane;
    logic            en;
    logic [HI_W-1:0] row_full;
    logic [RW-1:0]   row;
    logic [7:0]      mem_r [ROWS];
    logic [7:0]      q_r;

    // byte of the access that lands in this bank, and its row
    assign lane     = 3'(b) - cmd.addr[2:0];
    assign en       = issue && ({1'b0, lane} < cmd.nbytes);
    assign row_full = cmd.addr[bsta_pkg::ADDR_W-1:3] + HI_W'(3'(b) < cmd.addr[2:0]);
    assign row      = row_full[RW-1:0];

    always_ff @(posedge clk) begin
      if (en && cmd.write_en) begin
        mem_r[row] <= cmd.wdata[8*lane +: 8];
      end
    end

    always_ff @(posedge clk) begin
      if (en && cmd.read_en) begin
        q_r <= mem_r[row];
      end
    end

    assign bank_q[b] = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_base_r   <= cmd.addr[2:0];
      s2_n_r      <= cmd.nbytes;
      s2_read_r   <= cmd.read_en;
      s2_status_r <= cmd.status;
      s2_depth_r  <= cmd.depth;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [2:0] sel;
      sel = s2_base_r + 3'(i);
      rd_value[8*i +: 8] = (s2_read_r && (4'(i) < s2_n_r)) ? bank_q[sel] : 8'h00;
    end
  end

  assign res_wr         = s2_valid_r;
  assign res.read_value = rd_value;
  assign res.status     = s2_status_r;
  assign res.depth      = s2_depth_r;

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (out_count < CNT_W'(OUT_DEPTH)))
    else $error("result written into a full queue");

  a_stage_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> $past(issue))
    else $error("result stage valid without an issued command");

  a_read_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !(cmd.read_en && cmd.write_en))
    else $error("command both reads and writes");

  a_failed_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && (cmd.status != bsta_pkg::ST_OK)) |-> (!cmd.read_en && !cmd.write_en))
    else $error("failed operation touches the store");

endmodule

`default_nettype wire

FILE: rtl/byte_stack_typed_access_unit.sv
// top level of the byte stack typed access unit
`default_nettype none

// Operand stack held as a byte store with a top pointer. Each accepted item is
// push, pop, set, get or drop; every item gives exactly one result with the
// read value, a status code and the stack depth afterwards. The front checks
// bounds and updates the top pointer in the cycle an item is accepted and
// queues a command; the back issues commands to eight single-ported byte
// banks, one access per bank per cycle, so the unit sustains one item per
// clock while results are popped. A result passes the command queue, the
// bank read stage and the result queue. The command queue holds two entries
// and the result queue four; full rises when the command queue backs up.
// Store contents are undefined after reset and there is no clearing pass:
// only bytes below the top, which have all been written, are ever read.
module byte_stack_typed_access_unit #(
  parameter int DEPTH_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire bsta_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output bsta_pkg::out_item_t      out_item
);

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CW    = $clog2(OUT_DEPTH+1);

  logic                cmd_wr;
  bsta_pkg::cmd_t      cmd_in;
  bsta_pkg::cmd_t      cmd_out;
  logic                cmd_empty;
  logic                cmd_pop;
  logic                res_wr;
  bsta_pkg::out_item_t res;
  logic [OUT_CW-1:0]   out_count;

  bsta_front #(
    .DEPTH_BYTES (DEPTH_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .cmd_full (full),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in)
  );

  bsta_fifo #(
    .WIDTH ($bits(bsta_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty),
    .count   ()
  );

  bsta_back #(
    .DEPTH_BYTES (DEPTH_BYTES),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_wr    (res_wr),
    .res       (res)
  );

  bsta_fifo #(
    .WIDTH ($bits(bsta_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res),
    .full    (),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty),
    .count   (out_count)
  );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the byte stack typed access unit
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = 4096;
  localparam int CYCLE_LIMIT = 40000;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  bsta_pkg::in_item_t  in_item = '0;
  logic                empty;
  logic                pop = 1'b0;
  bsta_pkg::out_item_t out_item;

  // stack image kept alongside the block
  logic [7:0]  stack_bytes [STORE_BYTES];
  int unsigned model_top = 0;

  bsta_pkg::out_item_t expected_results [$];
  bsta_pkg::out_item_t oldest;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  byte_stack_typed_access_unit #(.DEPTH_BYTES(STORE_BYTES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // applies one operation to the stack image and returns the result it gives
  function automatic bsta_pkg::out_item_t apply_stack_op(bsta_pkg::in_item_t it);
    bsta_pkg::out_item_t r;
    int unsigned n;
    int unsigned off;
    int unsigned cnt;
    n = (it.access_bytes > bsta_pkg::LANES) ? bsta_pkg::LANES : it.access_bytes;
    off = it.byte_offset;
    cnt = it.drop_count;
    r.read_value = '0;
    r.status = bsta_pkg::ST_OK;
    case (it.opcode)
      bsta_pkg::OP_PUSH: begin
        if (model_top + n > STORE_BYTES) r.status = bsta_pkg::ST_OVERFLOW;
        else begin
          for (int i = 0; i < n; i++) stack_bytes[model_top + i] = it.write_value[8*i +: 8];
          model_top += n;
        end
      end
      bsta_pkg::OP_POP: begin
        if (n > model_top) r.status = bsta_pkg::ST_UNDERFLOW;
        else begin
          model_top -= n;
          for (int i = 0; i < n; i++) r.read_value[8*i +: 8] = stack_bytes[model_top + i];
        end
      end
      bsta_pkg::OP_SET: begin
        if (off + n > model_top) r.status = bsta_pkg::ST_RANGE;
        else for (int i = 0; i < n; i++) stack_bytes[off + i] = it.write_value[8*i +: 8];
      end
      bsta_pkg::OP_GET: begin
        if (off + n > model_top) r.status = bsta_pkg::ST_RANGE;
        else for (int i = 0; i < n; i++) r.read_value[8*i +: 8] = stack_bytes[off + i];
      end
      bsta_pkg::OP_DROP: begin
        if (cnt > model_top) r.status = bsta_pkg::ST_UNDERFLOW;
        else model_top -= cnt;
      end
      default: ;
    endcase
    r.depth = model_top[12:0];
    return r;
  endfunction

  // push stays high between back-to-back transfers
  task automatic send_item(input logic [2:0] op, input int unsigned nbytes,
                           input int unsigned offset, input int unsigned count,
                           input logic [63:0] value);
    bsta_pkg::in_item_t it;
    it.opcode       = op;
    it.access_bytes = 4'(nbytes);
    it.byte_offset  = 12'(offset);
    it.drop_count   = 13'(count);
    it.write_value  = value;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    expected_results.push_back(apply_stack_op(it));
  endtask

  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_item);
        error_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_item.read_value !== oldest.read_value) begin
          $error("read_value: expected %h, got %h", oldest.read_value, out_item.read_value);
          error_count++;
        end
        if (out_item.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_item.status);
          error_count++;
        end
        if (out_item.depth !== oldest.depth) begin
          $error("depth: expected %0d, got %0d", oldest.depth, out_item.depth);
          error_count++;
        end
      end
    end
  end

  // failures on an empty stack, zero-size accesses and unused opcodes
  task automatic test_empty_stack();
    send_item(bsta_pkg::OP_POP, 1, 0, 0, rand64());
    send_item(bsta_pkg::OP_DROP, 1, 0, 1, rand64());
    send_item(bsta_pkg::OP_GET, 1, 0, 0, rand64());
    send_item(bsta_pkg::OP_SET, 8, 4095, 0, '1);
    send_item(bsta_pkg::OP_POP, 0, 0, 0, rand64());
    send_item(bsta_pkg::OP_DROP, 8, 0, 0, rand64());
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      send_item(3'(op), 8, 4095, 8191, '1);
  endtask

  // widths 1, 4, 8, odd widths and saturating widths, little-endian order
  task automatic test_widths();
    send_item(bsta_pkg::OP_PUSH, 1, 0, 0, 64'h0123_4567_89ab_cda5);
    send_item(bsta_pkg::OP_PUSH, 4, 0, 0, 64'hffff_ffff_dead_beef);
    send_item(bsta_pkg::OP_PUSH, 8, 4095, 8191, '1);
    send_item(bsta_pkg::OP_GET, 8, 0, 0, '0);
    send_item(bsta_pkg::OP_SET, 4, 1, 0, 64'h5555_5555_1122_3344);
    send_item(bsta_pkg::OP_GET, 8, 5, 0, '0);
    send_item(bsta_pkg::OP_GET, 9, 5, 0, '0);
    send_item(bsta_pkg::OP_GET, 1, 13, 0, '0);
    send_item(bsta_pkg::OP_SET, 0, 13, 0, '1);
    send_item(bsta_pkg::OP_PUSH, 15, 0, 0, 64'h8000_0000_0000_0001);
    send_item(bsta_pkg::OP_PUSH, 3, 0, 0, 64'h0000_0000_00c0_ffee);
    send_item(bsta_pkg::OP_POP, 11, 0, 0, '0);
    send_item(bsta_pkg::OP_POP, 3, 0, 0, '0);
    send_item(bsta_pkg::OP_DROP, 0, 0, 8191, '0);
    send_item(bsta_pkg::OP_POP, 8, 0, 0, '0);
    send_item(bsta_pkg::OP_DROP, 0, 0, 5, '0);
  endtask

  // fill to capacity, hit overflow, work at the very top, then empty it
  task automatic test_full_stack();
    while (model_top + 8 <= STORE_BYTES) send_item(bsta_pkg::OP_PUSH, 8, 0, 0, rand64());
    while (model_top < STORE_BYTES) send_item(bsta_pkg::OP_PUSH, 1, 0, 0, rand64());
    send_item(bsta_pkg::OP_PUSH, 1, 0, 0, rand64());
    send_item(bsta_pkg::OP_PUSH, 0, 0, 0, rand64());
    send_item(bsta_pkg::OP_GET, 1, 4095, 0, '0);
    send_item(bsta_pkg::OP_GET, 2, 4095, 0, '0);
    send_item(bsta_pkg::OP_SET, 8, 4088, 0, rand64());
    send_item(bsta_pkg::OP_GET, 8, 4088, 0, '0);
    send_item(bsta_pkg::OP_POP, 4, 0, 0, '0);
    send_item(bsta_pkg::OP_DROP, 0, 0, 4096, '0);
    send_item(bsta_pkg::OP_DROP, 0, 0, model_top, '0);
    send_item(bsta_pkg::OP_DROP, 0, 0, 1, '0);
  endtask

  // mostly legal operations against the current depth, with some raw noise
  task automatic test_random_ops(input int count);
    int unsigned pick;
    int unsigned n;
    int unsigned off;
    int unsigned lim;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      case ($urandom_range(2))
        0: n = 1;
        1: n = 4;
        default: n = 8;
      endcase
      if ($urandom_range(9) == 0) n = $urandom_range(15);
      if (pick < 10) begin
        send_item(3'($urandom_range(7)), $urandom_range(15), $urandom_range(4095),
                  $urandom_range(8191), rand64());
      end else if (pick < 40 && model_top < 3500) begin
        send_item(bsta_pkg::OP_PUSH, n, $urandom_range(4095), $urandom_range(8191),
                  rand64());
      end else if (pick < 60) begin
        send_item(bsta_pkg::OP_POP, n, $urandom_range(4095), $urandom_range(8191),
                  rand64());
      end else if (pick < 92) begin
        if (n <= model_top) begin
          off = $urandom_range(model_top - n);
          if ($urandom_range(7) == 0) off = model_top - n + 1;
        end else off = $urandom_range(4095);
        if (off > 4095) off = 4095;
        send_item((pick < 75) ? bsta_pkg::OP_SET : bsta_pkg::OP_GET, n, off,
                  $urandom_range(8191), rand64());
      end else begin
        lim = (model_top < 16) ? model_top + 1 : 16;
        send_item(bsta_pkg::OP_DROP, n, $urandom_range(4095), $urandom_range(lim),
                  rand64());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 51;
    test_empty_stack();
    test_widths();
    test_random_ops(30);

    send_idle_pct = 51;
    recv_idle_pct = 33;
    test_full_stack();
    test_random_ops(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(30);

    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
